// File: rtl/lse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// Types, codes and constants shared by the stego payload extractor modules.
// ----------------------------------------------------------------------------
package lse_pkg;

   localparam int unsigned MaxExtLenDefault = 32;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 64;

   localparam logic [15:0] HeaderSkipReset  = 16'd54;
   localparam logic [63:0] MagicWordReset   = 64'd10787;
   localparam logic [3:0]  MagicLengthReset = 4'd2;
   localparam logic [3:0]  MagicLengthMin   = 4'd1;
   localparam logic [3:0]  MagicLengthMax   = 4'd8;

   // Last bit position of an 8-bit character and of a 32-bit word.
   localparam logic [4:0] CharLastBit = 5'd7;
   localparam logic [4:0] WordLastBit = 5'd31;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HEADER_SKIP  = 2'd0,
      CSR_MAGIC_WORD   = 2'd1,
      CSR_MAGIC_LENGTH = 2'd2
   } lse_csr_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_MAGIC  = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_EXT    = 3'd3,
      PH_SIZE   = 3'd4,
      PH_DATA   = 3'd5
   } lse_phase_type;

   typedef enum logic [1:0] {
      KIND_EXT    = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_STATUS = 2'd2
   } lse_kind_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_MAGIC  = 3'd1,
      ST_EXTLEN = 3'd2,
      ST_ZERO   = 3'd3,
      ST_TRUNC  = 3'd4
   } lse_status_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       image_start;
      logic       image_end;
   } lse_item_type;

   typedef struct packed {
      logic [7:0]     out_byte;
      lse_kind_type   kind;
      lse_status_type status;
      logic           last;
   } lse_result_type;

   typedef struct packed {
      logic [15:0] header_skip;
      logic [63:0] magic_word;
      logic [3:0]  magic_length;
   } lse_cfg_type;

   typedef struct packed {
      lse_phase_type phase;
      logic          finished;
   } lse_stat_type;

endpackage : lse_pkg
`default_nettype wire

// File: rtl/lse_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse channel interfaces
// Valid/ready channels for image bytes, decoded words and register writes.
// ----------------------------------------------------------------------------
interface lse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       image_start;
   logic       image_end;

   modport source (output valid, pixel_byte, image_start, image_end, input ready);
   modport sink   (input valid, pixel_byte, image_start, image_end, output ready);
endinterface : lse_req_if

interface lse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] kind;
   logic [2:0] status;
   logic       last;

   modport source (output valid, out_byte, kind, status, last, input ready);
   modport sink   (input valid, out_byte, kind, status, last, output ready);
endinterface : lse_rsp_if

interface lse_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lse_pkg::CsrIndexWidth-1:0] index;
   logic [lse_pkg::CsrDataWidth-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : lse_csr_if
`default_nettype wire

// File: rtl/lse_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_parse
// Parser state and one-byte step: header skip, bit gathering, field checks.
// ----------------------------------------------------------------------------
module lse_parse #(
   parameter int unsigned MAX_EXT_LEN = lse_pkg::MaxExtLenDefault
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     step,
   input  lse_pkg::lse_item_type   item,
   input  lse_pkg::lse_cfg_type    cfg,
   output logic                    res_valid,
   output lse_pkg::lse_result_type res,
   output lse_pkg::lse_stat_type   stat
);

   localparam int unsigned ExtW = $clog2(MAX_EXT_LEN);

   lse_pkg::lse_phase_type phase_ff, phase_in;
   logic [15:0]     header_count_ff, header_count_in;
   logic [4:0]      bit_index_ff, bit_index_in;
   logic [31:0]     shift_acc_ff, shift_acc_in;
   logic [31:0]     item_count_ff, item_count_in;
   logic [ExtW-1:0] ext_length_ff, ext_length_in;
   logic [31:0]     payload_size_ff, payload_size_in;
   logic            finished_ff, finished_in;

   // Effective state once a start marker has been applied.
   lse_pkg::lse_phase_type ph, ph_bits;
   logic [15:0]     hc;
   logic [4:0]      bi;
   logic [31:0]     acc, acc_new, ic, ic_inc, psize;
   logic [ExtW-1:0] ext;
   logic            fin, hdr_wait, wide, done_word;
   logic [3:0]      ml;
   logic [7:0]      want;
   logic            magic_ok, ext_ok, size_ok, err, data_last, fin_new, trunc;
   lse_pkg::lse_status_type err_code;

   always_comb begin
      ph    = item.image_start ? lse_pkg::PH_HEADER : phase_ff;
      hc    = item.image_start ? 16'd0 : header_count_ff;
      bi    = item.image_start ? 5'd0 : bit_index_ff;
      acc   = item.image_start ? 32'd0 : shift_acc_ff;
      ic    = item.image_start ? 32'd0 : item_count_ff;
      ext   = item.image_start ? '0 : ext_length_ff;
      psize = item.image_start ? 32'd0 : payload_size_ff;
      fin   = item.image_start ? 1'b0 : finished_ff;

      hdr_wait  = (ph == lse_pkg::PH_HEADER) && (hc < cfg.header_skip);
      ph_bits   = (ph == lse_pkg::PH_HEADER) ? lse_pkg::PH_MAGIC : ph;
      wide      = (ph_bits == lse_pkg::PH_EXTLEN) || (ph_bits == lse_pkg::PH_SIZE);
      acc_new   = acc | (32'(item.pixel_byte[0]) << bi);
      done_word = !hdr_wait && (bi == (wide ? lse_pkg::WordLastBit : lse_pkg::CharLastBit));
      ic_inc    = ic + 32'd1;

      // Clamp the magic length into 1..8.
      if (cfg.magic_length < lse_pkg::MagicLengthMin) begin
         ml = lse_pkg::MagicLengthMin;
      end else if (cfg.magic_length > lse_pkg::MagicLengthMax) begin
         ml = lse_pkg::MagicLengthMax;
      end else begin
         ml = cfg.magic_length;
      end

      want     = cfg.magic_word[{ic[2:0], 3'b000} +: 8];
      magic_ok = acc_new[7:0] == want;
      ext_ok   = (acc_new != 32'd0) && (acc_new < 32'(MAX_EXT_LEN));
      size_ok  = acc_new != 32'd0;

      err      = 1'b0;
      err_code = lse_pkg::ST_OK;
      if (done_word) begin
         case (ph_bits)
            lse_pkg::PH_MAGIC: begin
               err      = !magic_ok;
               err_code = lse_pkg::ST_MAGIC;
            end
            lse_pkg::PH_EXTLEN: begin
               err      = !ext_ok;
               err_code = lse_pkg::ST_EXTLEN;
            end
            lse_pkg::PH_SIZE: begin
               err      = !size_ok;
               err_code = lse_pkg::ST_ZERO;
            end
            default: begin
               err      = 1'b0;
               err_code = lse_pkg::ST_OK;
            end
         endcase
      end

      data_last = done_word && (ph_bits == lse_pkg::PH_DATA) && (ic_inc >= psize);
      fin_new   = err || data_last;
      trunc     = item.image_end && !fin_new;
   end

   // Next state.
   always_comb begin
      phase_in        = ph;
      header_count_in = hc;
      bit_index_in    = bi;
      shift_acc_in    = acc;
      item_count_in   = ic;
      ext_length_in   = ext;
      payload_size_in = psize;
      finished_in     = fin;
      if (!fin) begin
         finished_in = fin_new || trunc;
         if (hdr_wait) begin
            header_count_in = hc + 16'd1;
         end else if (!done_word) begin
            phase_in     = ph_bits;
            shift_acc_in = acc_new;
            bit_index_in = bi + 5'd1;
         end else begin
            phase_in     = ph_bits;
            shift_acc_in = 32'd0;
            bit_index_in = 5'd0;
            unique case (ph_bits)
               lse_pkg::PH_MAGIC: begin
                  if (magic_ok) begin
                     if (ic_inc >= 32'(ml)) begin
                        item_count_in = 32'd0;
                        phase_in      = lse_pkg::PH_EXTLEN;
                     end else begin
                        item_count_in = ic_inc;
                     end
                  end
               end
               lse_pkg::PH_EXTLEN: begin
                  if (ext_ok) begin
                     ext_length_in = acc_new[ExtW-1:0];
                     item_count_in = 32'd0;
                     phase_in      = lse_pkg::PH_EXT;
                  end
               end
               lse_pkg::PH_EXT: begin
                  if (ic_inc >= 32'(ext)) begin
                     item_count_in = 32'd0;
                     phase_in      = lse_pkg::PH_SIZE;
                  end else begin
                     item_count_in = ic_inc;
                  end
               end
               lse_pkg::PH_SIZE: begin
                  if (size_ok) begin
                     payload_size_in = acc_new;
                     item_count_in   = 32'd0;
                     phase_in        = lse_pkg::PH_DATA;
                  end
               end
               default: begin
                  item_count_in = ic_inc;
               end
            endcase
         end
      end
   end

   // Result of this byte: an error wins over truncation, which wins over data.
   always_comb begin
      res_valid = 1'b0;
      res       = '{out_byte: 8'd0, kind: lse_pkg::KIND_STATUS,
                    status: lse_pkg::ST_OK, last: 1'b1};
      if (!fin) begin
         if (err) begin
            res_valid  = 1'b1;
            res.status = err_code;
         end else if (trunc) begin
            res_valid  = 1'b1;
            res.status = lse_pkg::ST_TRUNC;
         end else if (done_word && (ph_bits == lse_pkg::PH_EXT ||
                                    ph_bits == lse_pkg::PH_DATA)) begin
            res_valid    = 1'b1;
            res.out_byte = acc_new[7:0];
            res.kind     = (ph_bits == lse_pkg::PH_EXT) ? lse_pkg::KIND_EXT
                                                         : lse_pkg::KIND_DATA;
            res.last     = data_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= lse_pkg::PH_HEADER;
         header_count_ff <= 16'd0;
         bit_index_ff    <= 5'd0;
         shift_acc_ff    <= 32'd0;
         item_count_ff   <= 32'd0;
         ext_length_ff   <= '0;
         payload_size_ff <= 32'd0;
         finished_ff     <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         bit_index_ff    <= bit_index_in;
         shift_acc_ff    <= shift_acc_in;
         item_count_ff   <= item_count_in;
         ext_length_ff   <= ext_length_in;
         payload_size_ff <= payload_size_in;
         finished_ff     <= finished_in;
      end
   end

   assign stat = '{phase: phase_ff, finished: finished_ff};

endmodule : lse_parse
`default_nettype wire

// File: rtl/lse_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_out_reg
// Result register: hold a decoded word until the sink takes it.
// ----------------------------------------------------------------------------
module lse_out_reg (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     load,
   input  lse_pkg::lse_result_type load_data,
   input  wire                     take,
   output logic                    space,
   output logic                    valid,
   output lse_pkg::lse_result_type data
);

   logic                    valid_ff, valid_in;
   lse_pkg::lse_result_type data_ff;

   assign space    = !valid_ff || take;
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule : lse_out_reg
`default_nettype wire

// File: rtl/lsb_stego_payload_extractor_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_stego_payload_extractor_core
// Stego image parser: pulls hidden LSB data out of an image byte stream.
// ----------------------------------------------------------------------------
// Path: a byte accepted into the input register passes through the combinational
//   parser step, and any word it forms is loaded into the result register.
// Throughput: one image byte per cycle while the result register has room; the parser
//   step is combinational logic between the input register and the result register.
// Reset: synchronous, active high; clears the parser to the start of an image
//   and loads the register defaults (skip 54, magic "#*", magic length 2).
module lsb_stego_payload_extractor_core #(
   parameter int unsigned MAX_EXT_LEN = lse_pkg::MaxExtLenDefault
) (
   input wire        clock,
   input wire        reset,
   lse_req_if.sink   req_ch,
   lse_rsp_if.source rsp_ch,
   lse_csr_if.sink   csr_ch
);

   // ---------------------------------------------------------------
   // Configuration registers; writes land any cycle.
   // ---------------------------------------------------------------
   lse_pkg::lse_cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_skip  <= lse_pkg::HeaderSkipReset;
         cfg_ff.magic_word   <= lse_pkg::MagicWordReset;
         cfg_ff.magic_length <= lse_pkg::MagicLengthReset;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            lse_pkg::CSR_HEADER_SKIP:  cfg_ff.header_skip  <= csr_ch.data[15:0];
            lse_pkg::CSR_MAGIC_WORD:   cfg_ff.magic_word   <= csr_ch.data;
            lse_pkg::CSR_MAGIC_LENGTH: cfg_ff.magic_length <= csr_ch.data[3:0];
            default: begin
               // Drop writes to unmapped indexes.
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Input register. It advances into the parser whenever the result
   // register has room, so a byte is taken every cycle the sink keeps up.
   // ---------------------------------------------------------------
   logic                  in_valid_ff, in_valid_in;
   lse_pkg::lse_item_type in_item_ff;
   logic                  advance, req_take, out_space;

   assign advance      = in_valid_ff && out_space;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{pixel_byte: req_ch.pixel_byte,
                         image_start: req_ch.image_start,
                         image_end: req_ch.image_end};
      end
   end

   // ---------------------------------------------------------------
   // Parser step: advance the state by one byte, form at most one word.
   // ---------------------------------------------------------------
   logic                    res_valid;
   lse_pkg::lse_result_type res;
   lse_pkg::lse_stat_type   stat;

   lse_parse #(
      .MAX_EXT_LEN (MAX_EXT_LEN)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res),
      .stat      (stat)
   );

   // ---------------------------------------------------------------
   // Result register; load only bytes that produced a word.
   // ---------------------------------------------------------------
   logic                    out_valid;
   lse_pkg::lse_result_type out_data;

   lse_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && res_valid),
      .load_data (res),
      .take      (rsp_ch.ready),
      .space     (out_space),
      .valid     (out_valid),
      .data      (out_data)
   );

   assign rsp_ch.valid    = out_valid;
   assign rsp_ch.out_byte = out_data.out_byte;
   assign rsp_ch.kind     = out_data.kind;
   assign rsp_ch.status   = out_data.status;
   assign rsp_ch.last     = out_data.last;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Once finished, nothing comes out until a new image starts.
   a_quiet_after_finish: assert property (@(posedge clock) disable iff (reset)
      (advance && stat.finished && !in_item_ff.image_start) |-> !res_valid)
      else $error("word produced after image finished");

   // Every status-only word closes the image.
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid && res.kind == lse_pkg::KIND_STATUS) |=> stat.finished)
      else $error("status word did not finish the image");

   // A held input byte is never overwritten by a new accept.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_take)
      else $error("input register overrun");

   // Reset leaves the parser at the start of an image.
   a_reset_state: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (stat.phase == lse_pkg::PH_HEADER && !stat.finished))
      else $error("parser not at image start after reset");

endmodule : lsb_stego_payload_extractor_core
`default_nettype wire
